// ===== src/mau_pkg.sv =====
package mau_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_EXP = 2'd3;

  // Datapath commands issued by the controller.
  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_LOAD    = 3'd1;  // capture request, start reducing a
  localparam logic [2:0] CMD_RED_B   = 3'd2;  // reduce b (a result captured)
  localparam logic [2:0] CMD_MUL     = 3'd3;  // start acc*sq (or ra*rb) product
  localparam logic [2:0] CMD_SQR     = 3'd4;  // start sq*sq product
  localparam logic [2:0] CMD_STEP    = 3'd5;  // one shift-add step of active op

  typedef struct packed {
    logic [2:0] cmd;
    logic       fin_add;   // finalize add/sub result
    logic       take_mul;  // store product (or sq on the first multiply) into acc
    logic       take_sqr;  // store product into sq
    logic       shift_e;   // shift exponent right
  } mau_ctrl_t;

  typedef struct packed {
    logic       busy;      // serial unit still working
    logic       e_zero;    // remaining exponent is zero
    logic       e_lsb;     // exponent lsb
    logic       first;     // no multiply into acc yet
    logic [1:0] op;
    logic       n_zero;
  } mau_stat_t;

endpackage

// ===== src/mau_datapath.sv =====
module mau_datapath #(
  parameter int W = 31
) (
  input  logic               clk,
  input  logic               rst,
  input  mau_pkg::mau_ctrl_t ctrl,
  output mau_pkg::mau_stat_t stat,
  input  logic [1:0]         req_type,
  input  logic [W-1:0]       operand_a,
  input  logic [W-1:0]       operand_b,
  input  logic [W-1:0]       modulus,
  output logic [W-1:0]       result
);
  import mau_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [1:0]   op;
  logic [W-1:0] n, ra, rb, ex, sq, acc;
  logic         first;
  // Serial unit: modular multiply by doubling, scanning y from its MSB.
  // Reduction of x mod n is multiply by 1 with x unreduced, done as
  // bitwise remainder: r = 2r + bit, subtract n when r >= n.
  logic         busy, red_mode;
  logic [W-1:0] mx, my, macc;
  logic [CW-1:0] cnt;
  logic [W:0]   dbl, dbl_r, add, add_r;
  logic [W-1:0] step_val;

  always_comb begin
    dbl   = {macc, 1'b0} + (red_mode ? {{W{1'b0}}, my[W-1]} : '0);
    dbl_r = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
    add   = dbl_r + {1'b0, mx};
    add_r = (add >= {1'b0, n}) ? add - {1'b0, n} : add;
    if (!red_mode && my[W-1]) step_val = add_r[W-1:0];
    else step_val = dbl_r[W-1:0];
  end

  logic [W:0] s_add, s_sub;
  always_comb begin
    s_add = {1'b0, ra} + {1'b0, rb};
    if (s_add >= {1'b0, n}) s_add = s_add - {1'b0, n};
    s_sub = (ra >= rb) ? {1'b0, ra - rb} : {1'b0, ra} + {1'b0, n - rb};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      unique case (ctrl.cmd)
        CMD_LOAD: begin
          op <= req_type; n <= modulus; ex <= operand_b;
          first <= 1'b1; acc <= '0;
          my <= operand_a; macc <= '0; mx <= '0; red_mode <= 1'b1;
          cnt <= CW'(W); busy <= 1'b1;
        end
        CMD_RED_B: begin
          ra <= macc; sq <= macc;
          my <= ex; macc <= '0; red_mode <= 1'b1;
          cnt <= CW'(W); busy <= 1'b1;
        end
        CMD_MUL: begin
          mx <= (op == OP_EXP) ? acc : ra;
          my <= (op == OP_EXP) ? sq : macc;
          if (op != OP_EXP) rb <= macc;
          macc <= '0; red_mode <= 1'b0; cnt <= CW'(W); busy <= 1'b1;
        end
        CMD_SQR: begin
          mx <= sq; my <= sq; macc <= '0; red_mode <= 1'b0;
          cnt <= CW'(W); busy <= 1'b1;
        end
        CMD_STEP: begin
          macc <= step_val; my <= my << 1;
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) busy <= 1'b0;
        end
        default: ;
      endcase
      if (ctrl.fin_add) acc <= (op == OP_ADD) ? s_add[W-1:0] : s_sub[W-1:0];
      if (ctrl.take_mul) begin
        acc <= first ? sq : macc;
        first <= 1'b0;
      end
      if (ctrl.take_sqr) sq <= macc;
      if (ctrl.shift_e) ex <= ex >> 1;
      // rb is needed for add and sub after its reduction.
      if (ctrl.cmd == CMD_NONE && !busy && !ctrl.fin_add && !ctrl.take_mul
          && !ctrl.take_sqr && !ctrl.shift_e) rb <= macc;
    end
  end

  assign stat.busy   = busy;
  assign stat.e_zero = (ex == '0);
  assign stat.e_lsb  = ex[0];
  assign stat.first  = first;
  assign stat.op     = op;
  assign stat.n_zero = (n == '0);
  assign result      = (op == OP_MUL) ? macc : acc;
endmodule

// ===== src/mau_ctrl.sv =====
module mau_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               err,
  input  mau_pkg::mau_stat_t stat,
  output mau_pkg::mau_ctrl_t ctrl
);
  import mau_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_REDA  = 4'd1;
  localparam logic [3:0] S_REDB  = 4'd2;
  localparam logic [3:0] S_LATB  = 4'd3;
  localparam logic [3:0] S_MULW  = 4'd4;
  localparam logic [3:0] S_EBIT  = 4'd5;
  localparam logic [3:0] S_EMW   = 4'd6;
  localparam logic [3:0] S_ESW   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_CHK   = 4'd9;

  logic [3:0] state, state_next;
  logic       err_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

  always_comb begin
    state_next = state;
    err_next   = err;
    ctrl       = '0;
    unique case (state)
      S_IDLE: if (in_valid) begin
        ctrl.cmd = CMD_LOAD; state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.n_zero) begin
          err_next = 1'b1; state_next = S_DONE;
        end else begin
          err_next = 1'b0; ctrl.cmd = CMD_STEP; state_next = S_REDA;
        end
      end
      S_REDA: begin
        if (stat.busy) ctrl.cmd = CMD_STEP;
        else if (stat.op == OP_EXP) begin
          // The reduced base becomes the first square.
          ctrl.take_sqr = 1'b1; state_next = S_EBIT;
        end else begin
          ctrl.cmd = CMD_RED_B; state_next = S_REDB;
        end
      end
      S_REDB: begin
        if (stat.busy) ctrl.cmd = CMD_STEP;
        else if (stat.op == OP_MUL) begin
          ctrl.cmd = CMD_MUL; state_next = S_MULW;
        end else state_next = S_LATB;
      end
      S_LATB: begin
        ctrl.fin_add = 1'b0; state_next = S_MULW;
      end
      S_MULW: begin
        if (stat.op != OP_MUL) begin
          ctrl.fin_add = 1'b1; state_next = S_DONE;
        end else if (stat.busy) ctrl.cmd = CMD_STEP;
        else state_next = S_DONE;
      end
      S_EBIT: begin
        if (stat.e_zero) state_next = S_DONE;
        else if (stat.e_lsb) begin
          if (stat.first) begin
            ctrl.take_mul = 1'b1; ctrl.cmd = CMD_SQR; state_next = S_ESW;
          end else begin
            ctrl.cmd = CMD_MUL; state_next = S_EMW;
          end
        end else begin
          ctrl.cmd = CMD_SQR; state_next = S_ESW;
        end
      end
      S_EMW: begin
        if (stat.busy) ctrl.cmd = CMD_STEP;
        else begin
          ctrl.take_mul = 1'b1; ctrl.cmd = CMD_SQR; state_next = S_ESW;
        end
      end
      S_ESW: begin
        if (stat.busy) ctrl.cmd = CMD_STEP;
        else begin
          ctrl.take_sqr = 1'b1; ctrl.shift_e = 1'b1; state_next = S_EBIT;
        end
      end
      S_DONE: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      err   <= 1'b0;
    end else begin
      state <= state_next;
      err   <= err_next;
    end
  end
endmodule

// ===== src/modular_arithmetic_unit_top.sv =====
// Channel | Signals                                         | Direction
// request | in_valid, in_stall, req_type, operand_a/b, modulus | into block
// result  | out_valid, out_stall, result_value, modulus_error  | out of block
//
// One word is handled at a time; the input stalls from the accepting edge until the
// result is taken, and the next word can be taken once the block is idle again. A zero
// modulus goes straight to the result with the error flag set; add and subtract reduce
// a and b and then add or subtract; multiply reduces both and runs one serial product;
// exponentiation reduces a, squares for every remaining exponent bit and folds the
// square into acc for each set bit. Reset clears the controller; a stalled result holds.
module modular_arithmetic_unit_top #(
  parameter int OPERAND_WIDTH = 31
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               req_type,
  input  logic [OPERAND_WIDTH-1:0] operand_a,
  input  logic [OPERAND_WIDTH-1:0] operand_b,
  input  logic [OPERAND_WIDTH-1:0] modulus,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [OPERAND_WIDTH-1:0] result_value,
  output logic                     modulus_error
);
  import mau_pkg::*;

  mau_ctrl_t ctrl;
  mau_stat_t stat;
  logic [OPERAND_WIDTH-1:0] res;

  // The controller sequences the serial unit; the datapath holds all operands.
  mau_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .err(modulus_error), .stat, .ctrl
  );

  mau_datapath #(.W(OPERAND_WIDTH)) u_dp (
    .clk, .rst, .ctrl, .stat, .req_type, .operand_a, .operand_b, .modulus,
    .result(res)
  );

  // An empty exponent leaves acc at zero, so the result is forced to one.
  always_comb begin
    if (modulus_error) result_value = '0;
    else if (stat.op == OP_EXP && stat.first) result_value = OPERAND_WIDTH'(1);
    else result_value = res;
  end
endmodule

// ===== src/mau_checker.sv =====
module mau_assertions #(
  parameter int W = 31
) (
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_stall,
  input logic         out_valid,
  input logic         out_stall,
  input logic         modulus_error,
  input logic [W-1:0] result_value
);
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accepting while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_value))
    else $error("result dropped");
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && modulus_error |-> result_value == '0) else $error("error value");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid) else $error("result too early");
endmodule

bind modular_arithmetic_unit_top mau_assertions #(.W(OPERAND_WIDTH)) u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .modulus_error, .result_value
);
